@@ src/e2c_pkg.sv @@
// e2c_pkg: constants shared by the epoch-to-calendar converter.
// Reciprocals for the constant divisions, calendar offsets, field widths.
// No dependencies.
package e2c_pkg;

	// pipeline depth, input register to output register
	localparam int NSTG = 8;

	// payload widths
	localparam int IN_W    = 32;
	localparam int OUT_W   = 40;  // 36 field bits padded to whole bytes
	localparam int DAY_W   = 16;  // days since 1968-01-01, max 50441
	localparam int SOD_W   = 17;  // second of day
	localparam int SOH_W   = 12;  // second of hour
	localparam int YDAY_W  = 9;

	// seconds/86400 = (seconds >> 7) / 675, estimate low by at most one
	localparam int          DAY_SHIFT = 7;
	localparam logic [9:0]  DAY_DIV   = 10'd675;
	localparam logic [24:0] DAY_RCP   = 25'd25451658;   // floor(2^34 / 675)
	localparam int          DAY_RSH   = 34;

	// second of day / 3600 = (sod >> 4) / 225, exact
	localparam logic [16:0] HR_RCP    = 17'd74566;      // ceil(2^24 / 225)
	localparam logic [11:0] SEC_HOUR  = 12'd3600;

	// second of hour / 60 = (soh >> 2) / 15, exact
	localparam logic [10:0] MIN_RCP   = 11'd1093;       // ceil(2^14 / 15)
	localparam logic [5:0]  SEC_MIN   = 6'd60;

	// day count / 7, / 1461, / 365, all exact over the 16-bit day range
	localparam logic [16:0] WK_RCP    = 17'd74899;      // ceil(2^19 / 7)
	localparam logic [16:0] CYC_RCP   = 17'd91868;      // ceil(2^27 / 1461)
	localparam logic [16:0] YR_RCP    = 17'd91930;      // ceil(2^25 / 365)
	localparam logic [10:0] CYC_DAYS  = 11'((4 * 365) + 1);
	localparam logic [8:0]  YR_DAYS   = 9'd365;

	// calendar anchors
	localparam logic [9:0]  EPOCH_OFS = 10'(365 + 366);  // 1968-01-01 to 1970-01-01
	localparam logic [10:0] LEAP_DAY  = 11'(31 + 29);    // day index of 1 Mar, first day after 29 Feb in cycle
	localparam logic [7:0]  YR_FIRST  = 8'(2000 - 1968);
	localparam logic [7:0]  YR_LAST   = 8'(2099 - 1968);

	// cumulative day of year at the start of each month, common year
	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

endpackage

@@ src/epoch_to_calendar.sv @@
// epoch_to_calendar: Unix seconds to calendar date, weekday and time of day.
// Eight-stage pipeline of constant-reciprocal divisions and compares.
// Depends on e2c_pkg.

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00
// into second, minute, hour, weekday (1 Monday .. 7 Sunday), day of month,
// month and year minus 2000. Dates outside 2000..2099 give out_of_range = 1
// with every other field zero. Leap years are every fourth year, which is
// exact over 2000..2099. The block is a fully pipelined datapath: it takes
// one transfer per clock while the output is not stalled and gives one
// result per input, in order. Eight register stages hold each item from
// the input transfer to the result transfer. The depth is set by the chain
// of reciprocal multiplies (seconds to days, days to four-year cycles, then
// to years) and the month lookup, each taking its own stage. Every stage
// holds its contents while the output is stalled; a stage that is empty or
// moving on accepts new data, so back-to-back transfers flow without
// bubbles.
// No configuration, no state beyond the pipeline itself.
module epoch_to_calendar
	import e2c_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [31:0] epoch_seconds

	output logic             m_tvalid,
	input  logic             m_tready,
	// [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
	// [19:17] weekday, [24:20] day_of_month, [28:25] month_number,
	// [35:29] year_offset, [39:36] zero
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser    // [0] out_of_range
);

	// ---------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its successor loads.
	// ---------------------------------------------------------------
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld_q[NSTG-1];

	// ---------------------------------------------------------------
	// Stage registers
	// ---------------------------------------------------------------
	logic [IN_W-1:0]   t_s1, t_s2;
	logic [DAY_W-1:0]  qd_s2;
	logic [DAY_W-1:0]  d_s3, d_s4, d_s5, d_s6;
	logic [SOD_W-1:0]  sod_s3, sod_s4;
	logic [4:0]        hr_s4, hr_s5, hr_s6, hr_s7, hr_s8;
	logic [13:0]       q7_s4;
	logic [5:0]        cyc_s4;
	logic [SOH_W-1:0]  soh_s5, soh_s6;
	logic [2:0]        wd_s5, wd_s6, wd_s7, wd_s8;
	logic [5:0]        lp_s5, lp_s6;
	logic              adj_s5, adj_s6;
	logic [7:0]        yrs_s6;
	logic [5:0]        mn_s6, mn_s7, mn_s8;
	logic [5:0]        sec_s7, sec_s8;
	logic [YDAY_W-1:0] yday_s7;
	logic              leap_s7, oor_s7, oor_s8;
	logic [6:0]        yoff_s7, yoff_s8;
	logic [4:0]        dom_s8;
	logic [3:0]        mon_s8;

	// ---------------------------------------------------------------
	// Stage 2: estimate of whole days since 1970, low by at most one
	// ---------------------------------------------------------------
	logic [49:0] p_day;
	assign p_day = {25'd0, t_s1[IN_W-1:DAY_SHIFT]} * {25'd0, DAY_RCP};

	// ---------------------------------------------------------------
	// Stage 3: correct the day estimate, form second of day and the
	// day count from 1968-01-01
	// ---------------------------------------------------------------
	logic [24:0] day_prod, r0;
	logic        r_ge;
	logic [9:0]  r_fix;
	assign day_prod = {9'd0, qd_s2} * {15'd0, DAY_DIV};
	assign r0       = t_s2[IN_W-1:DAY_SHIFT] - day_prod;
	assign r_ge     = r0[10:0] >= {1'b0, DAY_DIV};
	assign r_fix    = r_ge ? 10'(r0[10:0] - {1'b0, DAY_DIV}) : r0[9:0];

	// ---------------------------------------------------------------
	// Stage 4: hour, day / 7 and day / 1461 by reciprocal multiply
	// ---------------------------------------------------------------
	logic [29:0] p_hr;
	logic [32:0] p_wk, p_cyc;
	assign p_hr  = {17'd0, sod_s3[SOD_W-1:4]} * {13'd0, HR_RCP};
	assign p_wk  = {17'd0, d_s3} * {16'd0, WK_RCP};
	assign p_cyc = {17'd0, d_s3} * {16'd0, CYC_RCP};

	// ---------------------------------------------------------------
	// Stage 5: remainders; position in the four-year cycle decides the
	// leap-day count and the day-of-year fixup after 29 February
	// ---------------------------------------------------------------
	logic [SOD_W-1:0] hr_sec;
	logic [SOD_W-1:0] soh_c;
	logic [DAY_W-1:0] wk_rem, cyc_rem;
	logic [10:0]      pos;
	logic             past_feb;
	assign hr_sec   = {12'd0, hr_s4} * {5'd0, SEC_HOUR};
	assign soh_c    = sod_s4 - hr_sec;
	assign wk_rem   = d_s4 - DAY_W'({2'd0, q7_s4} * 16'd7);
	assign cyc_rem  = d_s4 - DAY_W'({10'd0, cyc_s4} * {5'd0, CYC_DAYS});
	assign pos      = cyc_rem[10:0];
	assign past_feb = pos >= LEAP_DAY;

	// ---------------------------------------------------------------
	// Stage 6: years since 1968 and minute of hour
	// ---------------------------------------------------------------
	logic [DAY_W-1:0] yr_num;
	logic [32:0]      p_yr;
	logic [20:0]      p_mn;
	assign yr_num = d_s5 - {10'd0, lp_s5};
	assign p_yr   = {17'd0, yr_num} * {16'd0, YR_RCP};
	assign p_mn   = {11'd0, soh_s5[SOH_W-1:2]} * {10'd0, MIN_RCP};

	// ---------------------------------------------------------------
	// Stage 7: second of minute, day of year, leap flag and range check
	// ---------------------------------------------------------------
	logic [SOH_W-1:0] mn_sec;
	logic [SOH_W-1:0] sec_c;
	logic [DAY_W-1:0] yday_c;
	assign mn_sec = {6'd0, mn_s6} * {6'd0, SEC_MIN};
	assign sec_c  = soh_s6 - mn_sec;
	assign yday_c = d_s6 - DAY_W'({8'd0, yrs_s6} * {7'd0, YR_DAYS})
	                - {10'd0, lp_s6} + {15'd0, adj_s6};

	// ---------------------------------------------------------------
	// Stage 8: month by compare against month starts, highest match wins
	// ---------------------------------------------------------------
	logic [3:0]        mon_c;
	logic [YDAY_W-1:0] start_c, st_c;
	logic [YDAY_W-1:0] dom_c;

	always_comb begin
		mon_c   = 4'd1;
		start_c = '0;
		st_c    = '0;
		for (int k = 0; k < 12; k++) begin
			st_c = MONTH_START[k] + {8'd0, (k >= 2) && leap_s7};
			if (yday_s7 >= st_c) begin
				mon_c   = 4'(k + 1);
				start_c = st_c;
			end
		end
	end
	assign dom_c = yday_s7 - start_c + 9'd1;

	// ---------------------------------------------------------------
	// Payload registers, no reset
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			t_s1 <= s_tdata;
		end
		if (adv[1]) begin
			t_s2  <= t_s1;
			qd_s2 <= p_day[DAY_RSH+DAY_W-1:DAY_RSH];
		end
		if (adv[2]) begin
			sod_s3 <= {r_fix, t_s2[DAY_SHIFT-1:0]};
			d_s3   <= qd_s2 + (r_ge ? {6'd0, EPOCH_OFS} + 16'd1 : {6'd0, EPOCH_OFS});
		end
		if (adv[3]) begin
			d_s4   <= d_s3;
			sod_s4 <= sod_s3;
			hr_s4  <= p_hr[28:24];
			q7_s4  <= p_wk[32:19];
			cyc_s4 <= p_cyc[32:27];
		end
		if (adv[4]) begin
			d_s5   <= d_s4;
			soh_s5 <= soh_c[SOH_W-1:0];
			hr_s5  <= hr_s4;
			wd_s5  <= wk_rem[2:0] + 3'd1;
			lp_s5  <= cyc_s4 + {5'd0, past_feb};
			adj_s5 <= past_feb && (pos <= 11'(YR_DAYS));
		end
		if (adv[5]) begin
			d_s6   <= d_s5;
			lp_s6  <= lp_s5;
			adj_s6 <= adj_s5;
			soh_s6 <= soh_s5;
			hr_s6  <= hr_s5;
			wd_s6  <= wd_s5;
			yrs_s6 <= p_yr[32:25];
			mn_s6  <= p_mn[19:14];
		end
		if (adv[6]) begin
			sec_s7  <= sec_c[5:0];
			mn_s7   <= mn_s6;
			hr_s7   <= hr_s6;
			wd_s7   <= wd_s6;
			yday_s7 <= yday_c[YDAY_W-1:0];
			leap_s7 <= (yrs_s6[1:0] == 2'd0);
			oor_s7  <= (yrs_s6 < YR_FIRST) || (yrs_s6 > YR_LAST);
			yoff_s7 <= 7'(yrs_s6 - YR_FIRST);
		end
		if (adv[7]) begin
			oor_s8 <= oor_s7;
			if (oor_s7) begin
				sec_s8  <= '0;
				mn_s8   <= '0;
				hr_s8   <= '0;
				wd_s8   <= '0;
				dom_s8  <= '0;
				mon_s8  <= '0;
				yoff_s8 <= '0;
			end else begin
				sec_s8  <= sec_s7;
				mn_s8   <= mn_s7;
				hr_s8   <= hr_s7;
				wd_s8   <= wd_s7;
				dom_s8  <= dom_c[4:0];
				mon_s8  <= mon_c;
				yoff_s8 <= yoff_s7;
			end
		end
	end

	assign m_tdata = {4'd0, yoff_s8, mon_s8, dom_s8, wd_s8, hr_s8, mn_s8, sec_s8};
	assign m_tuser = oor_s8;

endmodule

@@ tb/epoch_to_calendar_tb.sv @@
// epoch_to_calendar_tb: self-checking bench for the Unix-seconds to calendar converter.
// Queue-fed stream driver, checking monitor, and a calendar predictor of its own.
// Depends on e2c_pkg and epoch_to_calendar.
module epoch_to_calendar_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import e2c_pkg::*;

	localparam int unsigned EPOCH_Y2K    = 32'd946684800;   // 2000-01-01 00:00:00
	localparam int unsigned EPOCH_Y2100  = 32'd4102444800;  // 2100-01-01 00:00:00
	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned DAYS_TO_1970 = 365 + 366;       // day count starts 1968-01-01
	localparam int unsigned CYCLE_DAYS   = 4 * 365 + 1;
	localparam int unsigned FEB29_IDX    = 31 + 29;
	localparam int unsigned YEAR_BASE    = 1968;
	localparam int unsigned YEAR_FIRST   = 2000;
	localparam int unsigned YEAR_LAST    = 2099;
	localparam int          RANDOM_ITEMS = 1900;
	localparam int          TAIL_ITEMS   = 150;  // no idling on either side for the last ones
	localparam int          DRAIN_AT     = 900;  // sender waits here for every result
	localparam int          HOLD_AT      = 400;  // receiver holds off once this many went in
	localparam int          HOLD_CYCLES  = 150;

	localparam int unsigned MONTH_FIRST_DAY [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	typedef struct packed {
		logic [5:0] second_of_minute;
		logic [5:0] minute_of_hour;
		logic [4:0] hour_of_day;
		logic [2:0] weekday;
		logic [4:0] day_of_month;
		logic [3:0] month_number;
		logic [6:0] year_offset;
		logic       out_of_range;
	} calendar_t;

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	logic [IN_W-1:0]  acc_epoch = '0;    // transfer taken by the block, seen in the following cycle
	logic             acc_stb   = 1'b0;
	logic             hold_off  = 1'b0;
	logic             hold_done = 1'b0;
	int               hold_cnt  = 0;

	logic [IN_W-1:0]  pending_epochs [$];
	calendar_t        calendar_due [$];
	int               n_items      = 0;
	int               launched     = 0;  // driver-owned
	int               accepted_cnt = 0;
	int               results_seen = 0;
	int               send_gap     = 0;
	int               recv_gap     = 0;
	int               mismatches   = 0;

	epoch_to_calendar u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Calendar split: days counted from 1968-01-01 (a Monday, first year of a leap cycle).
	// The day-of-year fix-up only applies inside the leap year of each cycle, after Feb 29.
	function automatic calendar_t to_calendar(input logic [IN_W-1:0] epoch);
		int unsigned secs_all, mins_all, hrs_all, days, cyc_pos, leap_cnt;
		int unsigned yrs, yday, year, mstart, mon, k;
		bit          is_leap, hit;
		calendar_t   c;
		secs_all = epoch;
		mins_all = secs_all / 60;
		hrs_all  = mins_all / 60;
		days     = hrs_all / 24 + DAYS_TO_1970;
		leap_cnt = days / CYCLE_DAYS;
		cyc_pos  = days % CYCLE_DAYS;
		if (cyc_pos >= FEB29_IDX)
			leap_cnt++;
		yrs  = (days - leap_cnt) / 365;
		yday = days - yrs * 365 - leap_cnt;
		if (cyc_pos <= 365 && cyc_pos >= FEB29_IDX)
			yday++;
		year    = yrs + YEAR_BASE;
		is_leap = (year % 4) == 0;
		mon     = 1;
		mstart  = 0;
		hit     = 1'b0;
		// scan months from December down; first month start at or below the day wins
		for (k = 12; k > 0 && !hit; k--) begin
			mstart = MONTH_FIRST_DAY[k-1] + ((k > 2 && is_leap) ? 1 : 0);
			if (yday >= mstart) begin
				mon = k;
				hit = 1'b1;
			end
		end
		c = '0;
		if (year < YEAR_FIRST || year > YEAR_LAST) begin
			c.out_of_range = 1'b1;
		end else begin
			c.second_of_minute = 6'(secs_all % 60);
			c.minute_of_hour   = 6'(mins_all % 60);
			c.hour_of_day      = 5'(hrs_all % 24);
			c.weekday          = 3'(days % 7 + 1);
			c.day_of_month     = 5'(yday - mstart + 1);
			c.month_number     = 4'(mon);
			c.year_offset      = 7'(year - YEAR_FIRST);
		end
		return c;
	endfunction

	// idle rate by phase: stretches without idling, light and heavy idling
	function automatic int idle_pct(input int n);
		case ((n / 128) % 3)
			0:       return 0;
			1:       return 12;
			default: return 35;
		endcase
	endfunction

	function automatic void field_check(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed corners, then random times
	initial begin
		int unsigned pick, day, v;
		pending_epochs = '{
			32'd0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
			EPOCH_Y2K - 1, EPOCH_Y2K,
			32'd951782400, 32'd951868799, 32'd951868800,   // around 2000-02-29
			32'd978307199, 32'd978307200,                  // end of a leap year
			32'd983404799, 32'd983404800,                  // Feb/Mar in a common year
			32'd3981312000, 32'd4007836799,                // 2096 leap day, last day of 2096
			EPOCH_Y2100 - 1, EPOCH_Y2100,
			32'd2147483647, 32'd2147483648, 32'd1234567890
		};
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 60) begin
				v = $urandom_range(EPOCH_Y2100 - 1, EPOCH_Y2K);
			end else if (pick < 80) begin
				// around midnight of a random day in range
				day = $urandom_range(36524, 0);
				v   = EPOCH_Y2K + day * SECS_PER_DAY + $urandom_range(2, 0) - 1;
			end else if (pick < 90) begin
				v = ($urandom_range(1, 0) ? EPOCH_Y2K : EPOCH_Y2100) - 100000
					+ $urandom_range(200000, 0);
			end else begin
				v = $urandom();
			end
			pending_epochs.push_back(v);
		end
		n_items = pending_epochs.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (!(accepted_cnt == n_items && results_seen == n_items));
		repeat (4 * NSTG) @(posedge clk);

		if (mismatches == 0 && calendar_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			if (calendar_due.size() != 0)
				$error("%0d expected results never arrived", calendar_due.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// sender: one transfer per item, random idle bursts, one pause for a full drain
	always @(posedge clk) begin
		logic            valid_nxt;
		logic [IN_W-1:0] data_nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			acc_stb  <= 1'b0;
		end else begin
			valid_nxt = s_tvalid;
			data_nxt  = s_tdata;
			acc_stb   <= s_tvalid && s_tready;
			acc_epoch <= s_tdata;
			if (s_tvalid && s_tready) begin
				valid_nxt    = 1'b0;
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!valid_nxt) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (!hold_off && launched < n_items - TAIL_ITEMS
						&& $urandom_range(99, 0) < idle_pct(launched)) begin
					send_gap = $urandom_range(18, 0);
				end else if (pending_epochs.size() != 0
						&& !(launched == DRAIN_AT && results_seen != DRAIN_AT)) begin
					data_nxt  = pending_epochs.pop_front();
					valid_nxt = 1'b1;
					launched++;
				end
			end
			s_tvalid <= valid_nxt;
			s_tdata  <= data_nxt;
		end
	end

	// long receiver hold-off, once, so the pipeline fills and back-pressures the input
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_off <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			hold_off <= hold_cnt > 1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_off  <= 1'b1;
			hold_done <= 1'b1;
		end
	end

	// receiver: predict on each taken input, check each result transfer in order
	always @(posedge clk) begin
		calendar_t want;
		logic      ready_nxt;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (acc_stb)
				calendar_due.push_back(to_calendar(acc_epoch));
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (calendar_due.size() == 0) begin
					$error("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = calendar_due.pop_front();
					field_check("second_of_minute", want.second_of_minute, m_tdata[5:0]);
					field_check("minute_of_hour", want.minute_of_hour, m_tdata[11:6]);
					field_check("hour_of_day", want.hour_of_day, m_tdata[16:12]);
					field_check("weekday", want.weekday, m_tdata[19:17]);
					field_check("day_of_month", want.day_of_month, m_tdata[24:20]);
					field_check("month_number", want.month_number, m_tdata[28:25]);
					field_check("year_offset", want.year_offset, m_tdata[35:29]);
					field_check("out_of_range", want.out_of_range, m_tuser);
				end
			end
			if (hold_off) begin
				ready_nxt = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				ready_nxt = 1'b0;
			end else if (results_seen < n_items - TAIL_ITEMS
					&& $urandom_range(99, 0) < idle_pct(results_seen + 200)) begin
				recv_gap  = $urandom_range(18, 0);
				ready_nxt = 1'b0;
			end else begin
				ready_nxt = 1'b1;
			end
			m_tready <= ready_nxt;
		end
	end

endmodule
